// ----- src/nearest_ray_sphere_pick_defines.svh -----
// ----------------------------------------------------------------------------
// nearest_ray_sphere_pick assertion macros
// Clocked on aclk, quiet while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef NEAREST_RAY_SPHERE_PICK_DEFINES_SVH
`define NEAREST_RAY_SPHERE_PICK_DEFINES_SVH

// same-cycle implication
`define NRSP_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("nrsp assertion failed");

// next-cycle implication
`define NRSP_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("nrsp assertion failed");

`endif

// ----- src/nrsp_pkg.sv -----
// ----------------------------------------------------------------------------
// nrsp_pkg
// Shared widths, codes and types of the ray/sphere pick block.
// ----------------------------------------------------------------------------
package nrsp_pkg;

    localparam int MAX_NODES  = 256;
    localparam int IDX_W      = $clog2(MAX_NODES);
    localparam int CNT_W      = 9;
    localparam int ID_W       = 16;
    localparam int COORD_W    = 24;
    localparam int DIR_W      = 16;
    localparam int RAD_W      = 16;
    localparam int RES_W      = 32;

    // config port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PICK_RADIUS = 1'b1;
    localparam logic [RAD_W-1:0]     RADIUS_RST      = 16'd800;

    // opcodes
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // distance pipeline widths
    localparam int V_W    = COORD_W + 1;        // centre - origin
    localparam int P_W    = V_W + DIR_W;        // v * dir
    localparam int T_W    = P_W + 2;            // sum of three
    localparam int Q_W    = T_W + DIR_W;        // dir * t
    localparam int RND_SH = 30;                 // Q.34 -> Q.4
    localparam int E_W    = Q_W + 2;
    localparam int ER_W   = E_W - RND_SH;
    localparam int SQ_W   = 2 * ER_W;
    localparam int D2_W   = SQ_W + 2;

    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] z;
    } nrsp_entry_t;

    typedef struct packed {
        logic            busy;
        logic            valid;
        logic            behind;
        logic [ID_W-1:0] id;
        logic [D2_W-1:0] dist_sq;
    } nrsp_res_t;

endpackage

// ----- src/nrsp_dist_pipe.sv -----
// ----------------------------------------------------------------------------
// nrsp_dist_pipe
// Seven-stage pipeline: squared distance from a centre to a ray, plus
// a flag for centres behind the origin. One entry per cycle.
// ----------------------------------------------------------------------------
module nrsp_dist_pipe (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                in_valid,
    input  logic [nrsp_pkg::ID_W-1:0]           in_id,
    input  logic signed [nrsp_pkg::COORD_W-1:0] cx,
    input  logic signed [nrsp_pkg::COORD_W-1:0] cy,
    input  logic signed [nrsp_pkg::COORD_W-1:0] cz,
    input  logic signed [nrsp_pkg::COORD_W-1:0] ox,
    input  logic signed [nrsp_pkg::COORD_W-1:0] oy,
    input  logic signed [nrsp_pkg::COORD_W-1:0] oz,
    input  logic signed [nrsp_pkg::DIR_W-1:0]   dx,
    input  logic signed [nrsp_pkg::DIR_W-1:0]   dy,
    input  logic signed [nrsp_pkg::DIR_W-1:0]   dz,
    output nrsp_pkg::nrsp_res_t                 res
);
    import nrsp_pkg::*;

    localparam int NSTG = 7;
    localparam logic signed [E_W-1:0] HALF = E_W'(1) <<< (RND_SH - 1);

    logic [NSTG-1:0] vld_reg, vld_next;

    // id tag rides along
    logic [ID_W-1:0] id_reg [NSTG];

    logic signed [V_W-1:0]   v1x_reg, v1y_reg, v1z_reg;
    logic signed [V_W-1:0]   v2x_reg, v2y_reg, v2z_reg;
    logic signed [P_W-1:0]   p2x_reg, p2y_reg, p2z_reg;
    logic signed [V_W-1:0]   v3x_reg, v3y_reg, v3z_reg;
    logic signed [T_W-1:0]   t3_reg;
    logic signed [V_W-1:0]   v4x_reg, v4y_reg, v4z_reg;
    logic signed [Q_W-1:0]   q4x_reg, q4y_reg, q4z_reg;
    logic                    bh4_reg, bh5_reg, bh6_reg, bh7_reg;
    logic signed [ER_W-1:0]  e5x_reg, e5y_reg, e5z_reg;
    logic [SQ_W-1:0]         s6x_reg, s6y_reg, s6z_reg;
    logic [D2_W-1:0]         d7_reg;

    logic signed [E_W-1:0]   ex, ey, ez;
    logic signed [SQ_W-1:0]  sx, sy, sz;

    always_comb begin
        vld_next = {vld_reg[NSTG-2:0], in_valid};
        // v*2^30 + half - dir*t, floor shift gives round half up
        ex = (E_W'(v4x_reg) <<< RND_SH) + HALF - E_W'(q4x_reg);
        ey = (E_W'(v4y_reg) <<< RND_SH) + HALF - E_W'(q4y_reg);
        ez = (E_W'(v4z_reg) <<< RND_SH) + HALF - E_W'(q4z_reg);
        sx = SQ_W'(e5x_reg) * SQ_W'(e5x_reg);
        sy = SQ_W'(e5y_reg) * SQ_W'(e5y_reg);
        sz = SQ_W'(e5z_reg) * SQ_W'(e5z_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        id_reg[0] <= in_id;
        for (int k = 1; k < NSTG; k++) begin
            id_reg[k] <= id_reg[k-1];
        end
        // stage 1: offset from origin
        v1x_reg <= V_W'(cx) - V_W'(ox);
        v1y_reg <= V_W'(cy) - V_W'(oy);
        v1z_reg <= V_W'(cz) - V_W'(oz);
        // stage 2: projection terms
        p2x_reg <= P_W'(v1x_reg) * P_W'(dx);
        p2y_reg <= P_W'(v1y_reg) * P_W'(dy);
        p2z_reg <= P_W'(v1z_reg) * P_W'(dz);
        v2x_reg <= v1x_reg;
        v2y_reg <= v1y_reg;
        v2z_reg <= v1z_reg;
        // stage 3: t
        t3_reg  <= T_W'(p2x_reg) + T_W'(p2y_reg) + T_W'(p2z_reg);
        v3x_reg <= v2x_reg;
        v3y_reg <= v2y_reg;
        v3z_reg <= v2z_reg;
        // stage 4: closest point along ray
        q4x_reg <= Q_W'(dx) * Q_W'(t3_reg);
        q4y_reg <= Q_W'(dy) * Q_W'(t3_reg);
        q4z_reg <= Q_W'(dz) * Q_W'(t3_reg);
        bh4_reg <= t3_reg[T_W-1];
        v4x_reg <= v3x_reg;
        v4y_reg <= v3y_reg;
        v4z_reg <= v3z_reg;
        // stage 5: rounded error vector
        e5x_reg <= ex[E_W-1:RND_SH];
        e5y_reg <= ey[E_W-1:RND_SH];
        e5z_reg <= ez[E_W-1:RND_SH];
        bh5_reg <= bh4_reg;
        // stage 6: squares
        s6x_reg <= sx;
        s6y_reg <= sy;
        s6z_reg <= sz;
        bh6_reg <= bh5_reg;
        // stage 7: sum
        d7_reg  <= D2_W'(s6x_reg) + D2_W'(s6y_reg) + D2_W'(s6z_reg);
        bh7_reg <= bh6_reg;
    end

    assign res.busy    = |vld_reg;
    assign res.valid   = vld_reg[NSTG-1];
    assign res.behind  = bh7_reg;
    assign res.id      = id_reg[NSTG-1];
    assign res.dist_sq = d7_reg;

endmodule

// ----- src/nearest_ray_sphere_pick.sv -----
// ----------------------------------------------------------------------------
// nearest_ray_sphere_pick
// Nearest ray/sphere hit over a loaded node table.
// ----------------------------------------------------------------------------
// Load items (opcode 0) write one table slot (id and centre). Query items
// (opcode 1) carry a ray origin and a unit direction and produce exactly
// one result item: the node whose centre lies closest to the ray, in front
// of the origin, with squared distance strictly below pick_radius squared;
// ties go to the lower slot. The table sits in one single-port memory read
// one slot per cycle, followed by a memory output register and a seven-stage
// distance pipeline that must drain before the result is posted. While a
// query runs s_ready is low; a finished result waits in the output register
// and loads are still taken meanwhile. Slots that were never loaded hold
// garbage, so node_count must only cover loaded slots. No clearing pass
// after reset. Configuration (node_count, pick_radius) is written through
// cfg_wr_en/cfg_index/cfg_wdata while the block is idle.
// ----------------------------------------------------------------------------
module nearest_ray_sphere_pick (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // configuration
    input  logic                                  cfg_wr_en,
    input  logic [nrsp_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [nrsp_pkg::CFG_DATA_W-1:0]       cfg_wdata,
    // item in
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic                                  s_opcode,
    input  logic [nrsp_pkg::IDX_W-1:0]            s_entry_index,
    input  logic [nrsp_pkg::ID_W-1:0]             s_entry_node_id,
    input  logic signed [nrsp_pkg::COORD_W-1:0]   s_centre_x,
    input  logic signed [nrsp_pkg::COORD_W-1:0]   s_centre_y,
    input  logic signed [nrsp_pkg::COORD_W-1:0]   s_centre_z,
    input  logic signed [nrsp_pkg::COORD_W-1:0]   s_origin_x,
    input  logic signed [nrsp_pkg::COORD_W-1:0]   s_origin_y,
    input  logic signed [nrsp_pkg::COORD_W-1:0]   s_origin_z,
    input  logic signed [nrsp_pkg::DIR_W-1:0]     s_dir_x,
    input  logic signed [nrsp_pkg::DIR_W-1:0]     s_dir_y,
    input  logic signed [nrsp_pkg::DIR_W-1:0]     s_dir_z,
    // item out
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic                                  m_hit_found,
    output logic [nrsp_pkg::ID_W-1:0]             m_hit_node_id,
    output logic [nrsp_pkg::RES_W-1:0]            m_hit_dist_sq
);
    import nrsp_pkg::*;

    // sequencer states
    localparam logic [1:0] ST_IDLE  = 2'd0;  // taking items
    localparam logic [1:0] ST_SCAN  = 2'd1;  // issuing table reads
    localparam logic [1:0] ST_DRAIN = 2'd2;  // pipeline emptying
    localparam logic [1:0] ST_DONE  = 2'd3;  // waiting for output register

    logic [1:0] state_reg, state_next;

    // configuration registers
    logic [CNT_W-1:0] node_count_reg, node_count_next;
    logic [RAD_W-1:0] pick_radius_reg, pick_radius_next;

    // per-query context, captured at accept
    logic [CNT_W-1:0]           n_reg, n_next;
    logic [RES_W-1:0]           r2_reg, r2_next;
    logic signed [COORD_W-1:0]  ox_reg, oy_reg, oz_reg;
    logic signed [DIR_W-1:0]    dx_reg, dy_reg, dz_reg;

    // scan counter and memory read port
    logic [CNT_W-1:0] rd_idx_reg, rd_idx_next;
    logic             rd_en;
    logic             rd_vld_reg;
    nrsp_entry_t      rd_q_reg;

    // table memory, one slot per node
    nrsp_entry_t      table_mem [MAX_NODES];
    nrsp_entry_t      wr_entry;

    // running best
    logic             found_reg, found_next;
    logic [RES_W-1:0] best_reg, best_next;
    logic [ID_W-1:0]  best_id_reg, best_id_next;

    // output register
    logic             m_valid_reg, m_valid_next;
    logic             m_found_reg, m_found_next;
    logic [ID_W-1:0]  m_id_reg, m_id_next;
    logic [RES_W-1:0] m_dist_reg, m_dist_next;

    logic             in_acc, load_acc, query_acc;
    logic             hit, better;
    nrsp_res_t        res;

    assign s_ready   = (state_reg == ST_IDLE);
    assign in_acc    = s_valid && s_ready;
    assign load_acc  = in_acc && (s_opcode == OP_LOAD);
    assign query_acc = in_acc && (s_opcode == OP_QUERY);

    assign wr_entry.id = s_entry_node_id;
    assign wr_entry.x  = s_centre_x;
    assign wr_entry.y  = s_centre_y;
    assign wr_entry.z  = s_centre_z;

    // a hit is below radius^2, which fits in RES_W bits
    assign hit    = res.valid && !res.behind
                    && (res.dist_sq[D2_W-1:RES_W] == '0)
                    && (res.dist_sq[RES_W-1:0] < r2_reg);
    // strict compare keeps the lower slot on ties
    assign better = !found_reg || (res.dist_sq[RES_W-1:0] < best_reg);

    always_comb begin
        state_next       = state_reg;
        node_count_next  = node_count_reg;
        pick_radius_next = pick_radius_reg;
        n_next           = n_reg;
        r2_next          = r2_reg;
        rd_idx_next      = rd_idx_reg;
        rd_en            = 1'b0;
        found_next       = found_reg;
        best_next        = best_reg;
        best_id_next     = best_id_reg;
        m_valid_next     = m_valid_reg;
        m_found_next     = m_found_reg;
        m_id_next        = m_id_reg;
        m_dist_next      = m_dist_reg;

        if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_NODE_COUNT:  node_count_next  = cfg_wdata[CNT_W-1:0];
                CFG_PICK_RADIUS: pick_radius_next = cfg_wdata[RAD_W-1:0];
                default: ;
            endcase
        end

        if (hit && better) begin
            found_next   = 1'b1;
            best_next    = res.dist_sq[RES_W-1:0];
            best_id_next = res.id;
        end

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (query_acc) begin
                    // counts past the table search the whole table
                    n_next       = (node_count_reg > CNT_W'(MAX_NODES)) ?
                                   CNT_W'(MAX_NODES) : node_count_reg;
                    r2_next      = RES_W'(pick_radius_reg) * RES_W'(pick_radius_reg);
                    rd_idx_next  = '0;
                    found_next   = 1'b0;
                    best_next    = '0;
                    best_id_next = '0;
                    state_next   = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (rd_idx_reg == n_reg) begin
                    state_next = ST_DRAIN;
                end else begin
                    rd_en       = 1'b1;
                    rd_idx_next = rd_idx_reg + CNT_W'(1);
                end
            end
            ST_DRAIN: begin
                if (!rd_vld_reg && !res.busy) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_found_next = found_reg;
                    m_id_next    = best_id_reg;
                    m_dist_next  = best_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            node_count_reg  <= '0;
            pick_radius_reg <= RADIUS_RST;
            rd_vld_reg      <= 1'b0;
            m_valid_reg     <= 1'b0;
            found_reg       <= 1'b0;
        end else begin
            state_reg       <= state_next;
            node_count_reg  <= node_count_next;
            pick_radius_reg <= pick_radius_next;
            rd_vld_reg      <= rd_en;
            m_valid_reg     <= m_valid_next;
            found_reg       <= found_next;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        n_reg       <= n_next;
        r2_reg      <= r2_next;
        rd_idx_reg  <= rd_idx_next;
        best_reg    <= best_next;
        best_id_reg <= best_id_next;
        m_found_reg <= m_found_next;
        m_id_reg    <= m_id_next;
        m_dist_reg  <= m_dist_next;
        if (query_acc) begin
            ox_reg <= s_origin_x;
            oy_reg <= s_origin_y;
            oz_reg <= s_origin_z;
            dx_reg <= s_dir_x;
            dy_reg <= s_dir_y;
            dz_reg <= s_dir_z;
        end
    end

    // node table: loads only in idle, reads only while scanning
    always_ff @(posedge aclk) begin
        if (load_acc) begin
            table_mem[s_entry_index] <= wr_entry;
        end
        if (rd_en) begin
            rd_q_reg <= table_mem[rd_idx_reg[IDX_W-1:0]];
        end
    end

    nrsp_dist_pipe u_dist (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (rd_vld_reg),
        .in_id    (rd_q_reg.id),
        .cx       ($signed(rd_q_reg.x)),
        .cy       ($signed(rd_q_reg.y)),
        .cz       ($signed(rd_q_reg.z)),
        .ox       (ox_reg),
        .oy       (oy_reg),
        .oz       (oz_reg),
        .dx       (dx_reg),
        .dy       (dy_reg),
        .dz       (dz_reg),
        .res      (res)
    );

    assign m_valid       = m_valid_reg;
    assign m_hit_found   = m_found_reg;
    assign m_hit_node_id = m_id_reg;
    assign m_hit_dist_sq = m_dist_reg;

endmodule

// ----- src/nrsp_checker.sv -----
// ----------------------------------------------------------------------------
// nrsp_checker
// Port-level checks of nearest_ray_sphere_pick, bound to the top level.
// ----------------------------------------------------------------------------
`include "nearest_ray_sphere_pick_defines.svh"

module nrsp_checker (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    input  logic                                  s_ready,
    input  logic                                  s_opcode,
    input  logic                                  m_valid,
    input  logic                                  m_ready,
    input  logic                                  m_hit_found,
    input  logic [nrsp_pkg::ID_W-1:0]             m_hit_node_id,
    input  logic [nrsp_pkg::RES_W-1:0]            m_hit_dist_sq
);
    import nrsp_pkg::*;

    // stalled result holds
    `NRSP_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_hit_found) && $stable(m_hit_node_id) && $stable(m_hit_dist_sq))

    // a miss reports zero id and distance
    `NRSP_ASSERT_NOW(a_miss_zero, m_valid && !m_hit_found, (m_hit_node_id == '0) && (m_hit_dist_sq == '0))

    // a query occupies the block
    `NRSP_ASSERT_NEXT(a_query_busy, s_valid && s_ready && (s_opcode == OP_QUERY), !s_ready)

    // a load never yields a result
    `NRSP_ASSERT_NEXT(a_load_silent, s_valid && s_ready && (s_opcode == OP_LOAD) && !m_valid, !m_valid)

endmodule

bind nearest_ray_sphere_pick nrsp_checker u_nrsp_checker (.*);

// ----- test/tb_nearest_ray_sphere_pick.sv -----
// ----------------------------------------------------------------------------
// tb_nearest_ray_sphere_pick
// Self-checking bench for the nearest ray/sphere pick block.
// ----------------------------------------------------------------------------
// A short directed table covers the empty table, centres and directions at
// their extremes, the start point sitting on a centre (t == 0), nodes behind
// the origin, a zero and a non-unit direction, equal centres (lower slot
// wins) and the zero and full-scale radius. Then the whole table is filled
// and random phases follow, each with its own node_count, radius and
// idling. Most queries aim at a loaded node; some are junk rays and some
// reload slots. Each result is compared with its typed want or the predictor.
// ----------------------------------------------------------------------------
module tb_nearest_ray_sphere_pick;
    timeunit 1ns;
    timeprecision 1ps;

    import nrsp_pkg::*;

    localparam logic signed [COORD_W-1:0] CMAX    = 24'sh7FFFFF;
    localparam logic signed [COORD_W-1:0] CMIN    = 24'sh800000;
    localparam logic signed [DIR_W-1:0]   DMAX    = 16'sh7FFF;
    localparam logic signed [DIR_W-1:0]   DMIN    = 16'sh8000;
    localparam int                        CLUSTER = 65536;  // +-4096 units

    typedef struct packed {
        logic                      op;
        logic [IDX_W-1:0]          slot;
        logic [ID_W-1:0]           node_id;
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        logic signed [COORD_W-1:0] cz;
        logic signed [COORD_W-1:0] ox;
        logic signed [COORD_W-1:0] oy;
        logic signed [COORD_W-1:0] oz;
        logic signed [DIR_W-1:0]   dx;
        logic signed [DIR_W-1:0]   dy;
        logic signed [DIR_W-1:0]   dz;
    } pick_item_t;

    typedef struct packed {
        logic             found;
        logic [ID_W-1:0]  id;
        logic [RES_W-1:0] sq_dist;
    } pick_res_t;

    // one line of the directed table: a register write or an item
    typedef struct packed {
        logic                  cfg_wr;
        logic [CFG_IDX_W-1:0]  cfg_sel;
        logic [CFG_DATA_W-1:0] cfg_val;
        pick_item_t            item;
        logic                  typed;   // want below is fixed, no prediction
        pick_res_t             want;
    } drill_row_t;

    logic                         aclk            = 1'b0;
    logic                         aresetn         = 1'b0;
    logic                         cfg_wr_en       = 1'b0;
    logic [CFG_IDX_W-1:0]         cfg_index       = '0;
    logic [CFG_DATA_W-1:0]        cfg_wdata       = '0;
    logic                         s_valid         = 1'b0;
    logic                         s_ready;
    logic                         s_opcode        = 1'b0;
    logic [IDX_W-1:0]             s_entry_index   = '0;
    logic [ID_W-1:0]              s_entry_node_id = '0;
    logic signed [COORD_W-1:0]    s_centre_x      = '0;
    logic signed [COORD_W-1:0]    s_centre_y      = '0;
    logic signed [COORD_W-1:0]    s_centre_z      = '0;
    logic signed [COORD_W-1:0]    s_origin_x      = '0;
    logic signed [COORD_W-1:0]    s_origin_y      = '0;
    logic signed [COORD_W-1:0]    s_origin_z      = '0;
    logic signed [DIR_W-1:0]      s_dir_x         = '0;
    logic signed [DIR_W-1:0]      s_dir_y         = '0;
    logic signed [DIR_W-1:0]      s_dir_z         = '0;
    logic                         m_valid;
    logic                         m_ready         = 1'b0;
    logic                         m_hit_found;
    logic [ID_W-1:0]              m_hit_node_id;
    logic [RES_W-1:0]             m_hit_dist_sq;

    // bench-side copy of the node table and registers
    logic [ID_W-1:0]              node_ids [MAX_NODES];
    logic signed [COORD_W-1:0]    node_x   [MAX_NODES];
    logic signed [COORD_W-1:0]    node_y   [MAX_NODES];
    logic signed [COORD_W-1:0]    node_z   [MAX_NODES];
    logic [CNT_W-1:0]             cur_count;
    logic [RAD_W-1:0]             cur_radius;

    pick_res_t                    pending_picks [$];
    int                           mismatches = 0;
    int                           src_idle   = 0;   // percent of cycles sender holds off
    int                           dst_stall  = 0;   // percent of cycles m_ready is low

    nearest_ray_sphere_pick uut (.*);

    always #5 aclk = ~aclk;

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------

    // Nearest node in front of the ray, strictly inside the radius. The
    // closest-point error is kept in Q.34, rounded half up to Q.4 per axis.
    function automatic pick_res_t predict_pick(input pick_item_t it);
        pick_res_t         res;
        longint            ox, oy, oz, dx, dy, dz;
        longint            vx, vy, vz, t, ex, ey, ez;
        longint unsigned   d2, r2, best;
        int                n, i;
        res  = '0;
        best = 0;
        ox   = longint'(it.ox);
        oy   = longint'(it.oy);
        oz   = longint'(it.oz);
        dx   = longint'(it.dx);
        dy   = longint'(it.dy);
        dz   = longint'(it.dz);
        r2   = longint'(cur_radius) * longint'(cur_radius);
        n    = (cur_count > MAX_NODES) ? MAX_NODES : int'(cur_count);
        for (i = 0; i < n; i++) begin
            vx = longint'(node_x[i[IDX_W-1:0]]) - ox;
            vy = longint'(node_y[i[IDX_W-1:0]]) - oy;
            vz = longint'(node_z[i[IDX_W-1:0]]) - oz;
            t  = vx * dx + vy * dy + vz * dz;
            if (t >= 0) begin
                ex = (vx * (longint'(1) << 30) - dx * t + (longint'(1) << 29)) >>> 30;
                ey = (vy * (longint'(1) << 30) - dy * t + (longint'(1) << 29)) >>> 30;
                ez = (vz * (longint'(1) << 30) - dz * t + (longint'(1) << 29)) >>> 30;
                d2 = ex * ex + ey * ey + ez * ez;
                if (d2 < r2 && (!res.found || d2 < best)) begin
                    best      = d2;
                    res.found = 1'b1;
                    res.id    = node_ids[i[IDX_W-1:0]];
                end
            end
        end
        res.sq_dist = best[RES_W-1:0];
        return res;
    endfunction

    function automatic void store_node(input pick_item_t it);
        node_ids[it.slot] = it.node_id;
        node_x[it.slot]   = it.cx;
        node_y[it.slot]   = it.cy;
        node_z[it.slot]   = it.cz;
    endfunction

    // ------------------------------------------------------------------------
    // item builders
    // ------------------------------------------------------------------------

    function automatic drill_row_t cfg_row(input logic [CFG_IDX_W-1:0] sel,
                                           input logic [CFG_DATA_W-1:0] val);
        drill_row_t r;
        r         = '0;
        r.cfg_wr  = 1'b1;
        r.cfg_sel = sel;
        r.cfg_val = val;
        return r;
    endfunction

    function automatic drill_row_t load_row(input logic [IDX_W-1:0] slot,
                                            input logic [ID_W-1:0] node_id,
                                            input logic signed [COORD_W-1:0] x, y, z);
        drill_row_t r;
        r              = '0;
        r.item.op      = OP_LOAD;
        r.item.slot    = slot;
        r.item.node_id = node_id;
        r.item.cx      = x;
        r.item.cy      = y;
        r.item.cz      = z;
        return r;
    endfunction

    function automatic drill_row_t ray_row(input logic signed [COORD_W-1:0] x, y, z,
                                           input logic signed [DIR_W-1:0] u, v, w,
                                           input logic typed, found,
                                           input logic [ID_W-1:0] id,
                                           input logic [RES_W-1:0] sq_dist);
        drill_row_t r;
        r              = '0;
        r.item.op      = OP_QUERY;
        r.item.ox      = x;
        r.item.oy      = y;
        r.item.oz      = z;
        r.item.dx      = u;
        r.item.dy      = v;
        r.item.dz      = w;
        r.typed        = typed;
        r.want.found   = found;
        r.want.id      = id;
        r.want.sq_dist = sq_dist;
        return r;
    endfunction

    function automatic logic signed [COORD_W-1:0] clamp_coord(input longint v);
        if (v > longint'(CMAX))
            return CMAX;
        if (v < longint'(CMIN))
            return CMIN;
        return v[COORD_W-1:0];
    endfunction

    // mostly clustered centres, some anywhere, some copies of another slot
    function automatic pick_item_t random_node(input logic [IDX_W-1:0] slot, input bit reuse);
        pick_item_t  it;
        int unsigned roll, src;
        it         = '0;
        it.op      = OP_LOAD;
        it.slot    = slot;
        it.node_id = ID_W'($urandom());
        it.ox      = COORD_W'($urandom());    // query-only fields carry junk
        it.dx      = DIR_W'($urandom());
        it.dz      = DIR_W'($urandom());
        roll       = $urandom_range(99);
        if (reuse && roll < 8) begin
            src   = $urandom_range(MAX_NODES - 1);
            it.cx = node_x[src[IDX_W-1:0]];
            it.cy = node_y[src[IDX_W-1:0]];
            it.cz = node_z[src[IDX_W-1:0]];
        end else if (roll < 20) begin
            it.cx = COORD_W'($urandom());
            it.cy = COORD_W'($urandom());
            it.cz = COORD_W'($urandom());
        end else begin
            it.cx = COORD_W'($urandom_range(2 * CLUSTER) - CLUSTER);
            it.cy = COORD_W'($urandom_range(2 * CLUSTER) - CLUSTER);
            it.cz = COORD_W'($urandom_range(2 * CLUSTER) - CLUSTER);
        end
        return it;
    endfunction

    // raw direction, usually not unit length; load fields carry junk
    function automatic pick_item_t noise_query();
        pick_item_t it;
        it         = '0;
        it.op      = OP_QUERY;
        it.slot    = IDX_W'($urandom());
        it.node_id = ID_W'($urandom());
        it.cx      = COORD_W'($urandom());
        it.cy      = COORD_W'($urandom());
        if ($urandom_range(1)) begin
            it.ox = COORD_W'($urandom());
            it.oy = COORD_W'($urandom());
            it.oz = COORD_W'($urandom());
        end else begin
            it.ox = COORD_W'($urandom_range(2 * CLUSTER) - CLUSTER);
            it.oy = COORD_W'($urandom_range(2 * CLUSTER) - CLUSTER);
            it.oz = COORD_W'($urandom_range(2 * CLUSTER) - CLUSTER);
        end
        it.dx = DIR_W'($urandom());
        it.dy = DIR_W'($urandom());
        it.dz = DIR_W'($urandom());
        return it;
    endfunction

    // Unit ray that passes near a searched node: the origin is backed off
    // along the direction and nudged by up to half the radius plus one per axis.
    // A small share lands past the node, leaving it behind the origin.
    function automatic pick_item_t aimed_query(input int unsigned span);
        pick_item_t  it;
        real         a, b, c, len, reach;
        int unsigned j;
        int          jit;
        it    = '0;
        it.op = OP_QUERY;
        j     = $urandom_range(span - 1);
        a     = real'($urandom_range(2000)) - 1000.0;
        b     = real'($urandom_range(2000)) - 1000.0;
        c     = real'($urandom_range(2000)) - 1000.0;
        len   = $sqrt(a * a + b * b + c * c);
        if (len < 1.0) begin
            a   = 1000.0;
            len = 1000.0;
        end
        a     = a / len;
        b     = b / len;
        c     = c / len;
        it.dx = DIR_W'($rtoi(a * 32767.0));
        it.dy = DIR_W'($rtoi(b * 32767.0));
        it.dz = DIR_W'($rtoi(c * 32767.0));
        reach = real'($urandom_range(40000)) - 4000.0;
        jit   = int'(cur_radius) / 2 + 1;
        it.ox = clamp_coord(longint'(node_x[j[IDX_W-1:0]]) - longint'($rtoi(a * reach))
                            + longint'($urandom_range(2 * jit)) - jit);
        it.oy = clamp_coord(longint'(node_y[j[IDX_W-1:0]]) - longint'($rtoi(b * reach))
                            + longint'($urandom_range(2 * jit)) - jit);
        it.oz = clamp_coord(longint'(node_z[j[IDX_W-1:0]]) - longint'($rtoi(c * reach))
                            + longint'($urandom_range(2 * jit)) - jit);
        return it;
    endfunction

    // ------------------------------------------------------------------------
    // driving
    // ------------------------------------------------------------------------

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatches++;
        if (mismatches <= 40)
            $display("[%0t] mismatch %s: got %0h, want %0h", $time, what, got, want);
    endtask

    task automatic wait_drained();
        while (pending_picks.size() != 0)
            @(posedge aclk);
    endtask

    // Offer one item, with random hold-off first; the expectation is queued
    // at the edge that accepts it.
    task automatic push_item(input pick_item_t it, input bit typed, input pick_res_t want);
        while ($urandom_range(99) < src_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_opcode        <= it.op;
        s_entry_index   <= it.slot;
        s_entry_node_id <= it.node_id;
        s_centre_x      <= it.cx;
        s_centre_y      <= it.cy;
        s_centre_z      <= it.cz;
        s_origin_x      <= it.ox;
        s_origin_y      <= it.oy;
        s_origin_z      <= it.oz;
        s_dir_x         <= it.dx;
        s_dir_y         <= it.dy;
        s_dir_z         <= it.dz;
        do @(posedge aclk); while (!s_ready);
        if (it.op == OP_LOAD)
            store_node(it);
        else
            pending_picks.push_back(typed ? want : predict_pick(it));
    endtask

    // Registers change only with the block idle: no result pending, and a
    // few spare cycles for a load that may still be landing.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] sel, input logic [CFG_DATA_W-1:0] val);
        s_valid <= 1'b0;
        wait_drained();
        repeat (16) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= sel;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (sel == CFG_NODE_COUNT)
            cur_count = val[CNT_W-1:0];
        else
            cur_radius = val[RAD_W-1:0];
    endtask

    // ------------------------------------------------------------------------
    // result check and receiver stalls
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin : result_check
        pick_res_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_picks.size() == 0) begin
                report_mismatch("result with no query pending", 64'(m_hit_node_id), 64'(0));
            end else begin
                want = pending_picks.pop_front();
                if (m_hit_found !== want.found)
                    report_mismatch("hit_found", 64'(m_hit_found), 64'(want.found));
                if (m_hit_node_id !== want.id)
                    report_mismatch("hit_node_id", 64'(m_hit_node_id), 64'(want.id));
                if (m_hit_dist_sq !== want.sq_dist)
                    report_mismatch("hit_dist_sq", 64'(m_hit_dist_sq), 64'(want.sq_dist));
            end
        end
        m_ready <= ($urandom_range(99) >= dst_stall);
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    initial begin
        drill_row_t  drill_q [$];
        pick_item_t  it;
        int          k, p, span;
        int unsigned roll;

        cur_count  = '0;
        cur_radius = RADIUS_RST;

        // directed table; rays with a typed result are readable at a glance
        // nothing loaded and node_count still zero: every ray misses
        drill_q.push_back(ray_row(CMAX, CMIN, 0, DMAX, DMIN, 0, 1, 0, 0, 0));
        drill_q.push_back(load_row(0, 16'hFFFF, 0, 0, 0));
        drill_q.push_back(load_row(1, 16'h0000, CMAX, CMAX, CMAX));
        drill_q.push_back(load_row(2, 16'h0001, CMIN, CMIN, CMIN));
        drill_q.push_back(load_row(3, 16'h1234, 1600, 0, 0));
        drill_q.push_back(load_row(4, 16'h4321, 1600, 0, 0));    // same centre as slot 3
        drill_q.push_back(load_row(5, 16'hA5A5, 800, 480, 0));
        drill_q.push_back(load_row(8'd255, 16'h5A5A, -4096, 4096, 12345));
        // one node, ray starting on its centre: t == 0 still counts
        drill_q.push_back(cfg_row(CFG_NODE_COUNT, 1));
        drill_q.push_back(ray_row(0, 0, 0, DMAX, 0, 0, 1, 1, 16'hFFFF, 0));
        drill_q.push_back(cfg_row(CFG_NODE_COUNT, 6));
        drill_q.push_back(ray_row(-800, 0, 0, DMAX, 0, 0, 0, 0, 0, 0));
        drill_q.push_back(ray_row(3200, 0, 0, DMAX, 0, 0, 0, 0, 0, 0));  // near nodes behind
        drill_q.push_back(ray_row(3200, 0, 0, DMIN, 0, 0, 0, 0, 0, 0));  // turned around
        drill_q.push_back(ray_row(1600, 0, 0, 0, 0, 0, 0, 0, 0, 0));     // zero direction
        drill_q.push_back(ray_row(0, 0, 0, DMAX, DMAX, DMAX, 0, 0, 0, 0)); // non-unit
        // corner origins: only the node sitting on the origin is not behind
        drill_q.push_back(ray_row(CMIN, CMIN, CMIN, DMIN, DMIN, DMIN, 1, 1, 16'h0001, 0));
        drill_q.push_back(ray_row(CMAX, CMAX, CMAX, DMAX, DMAX, DMAX, 1, 1, 16'h0000, 0));
        // zero radius: even a node on the ray start misses
        drill_q.push_back(cfg_row(CFG_PICK_RADIUS, 0));
        drill_q.push_back(ray_row(0, 0, 0, DMAX, 0, 0, 1, 0, 0, 0));
        drill_q.push_back(cfg_row(CFG_PICK_RADIUS, 16'hFFFF));
        drill_q.push_back(ray_row(-800, 100, -50, 16'sd23170, 16'sd23170, 0, 0, 0, 0, 0));
        drill_q.push_back(cfg_row(CFG_PICK_RADIUS, 800));

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (k = 0; k < drill_q.size(); k++) begin
            if (drill_q[k].cfg_wr)
                write_reg(drill_q[k].cfg_sel, drill_q[k].cfg_val);
            else
                push_item(drill_q[k].item, drill_q[k].typed, drill_q[k].want);
        end

        // fill every slot so any node_count reads loaded entries only
        for (k = 0; k < MAX_NODES; k++)
            push_item(random_node(IDX_W'(k), 1'b0), 1'b0, '0);

        // random phases: own registers and idling each
        for (p = 0; p < 12; p++) begin
            case (p % 4)
                0: begin
                    src_idle  = 0;
                    dst_stall = 0;
                end
                1: begin
                    src_idle  = 59;
                    dst_stall = 0;
                end
                2: begin
                    src_idle  = 0;
                    dst_stall = 59;
                end
                default: begin
                    src_idle  = 36;
                    dst_stall = 36;
                end
            endcase

            // whole table twice (once through the clamp above 256), empty
            // once, short walks otherwise
            if (p == 2)
                write_reg(CFG_NODE_COUNT, 16'd256);
            else if (p == 6)
                write_reg(CFG_NODE_COUNT, 16'hFFFF);
            else if (p == 9)
                write_reg(CFG_NODE_COUNT, 16'd0);
            else
                write_reg(CFG_NODE_COUNT, CFG_DATA_W'($urandom_range(1, 24)));
            if (p == 3)
                write_reg(CFG_PICK_RADIUS, 16'd0);
            else if (p == 7)
                write_reg(CFG_PICK_RADIUS, 16'hFFFF);
            else
                write_reg(CFG_PICK_RADIUS, CFG_DATA_W'($urandom_range(200, 6000)));

            span = (cur_count > MAX_NODES) ? MAX_NODES : int'(cur_count);
            for (k = 0; k < 20; k++) begin
                // now and then hold off until every pick is back
                if ((k == 10 || $urandom_range(15) == 0) && pending_picks.size() != 0) begin
                    s_valid <= 1'b0;
                    wait_drained();
                end
                roll = $urandom_range(99);
                if (roll < 15)
                    it = random_node(IDX_W'($urandom_range(MAX_NODES - 1)), 1'b1);
                else if (roll < 30 || span == 0)
                    it = noise_query();
                else
                    it = aimed_query(span);
                push_item(it, 1'b0, '0);
            end
        end

        s_valid <= 1'b0;
        wait_drained();
        repeat (40) @(posedge aclk);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // hang guard, several times the slowest legal run
    initial begin
        #10_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
